// ===== sv/fwrs_pkg.sv =====
// ----------------------------------------------------------------------------
// fwrs_pkg - shared definitions for the framed register write slave
// Sizes, frame constants and request codes used by the slave and its buffer.
// ----------------------------------------------------------------------------
package fwrs_pkg;

	// sizes
	localparam int RX_DEPTH  = 32;
	localparam int NUM_HREGS = 12;

	localparam int RX_AW     = $clog2(RX_DEPTH);
	localparam int CNT_W     = $clog2(RX_DEPTH + 1);
	localparam int HIDX_W    = (NUM_HREGS > 1) ? $clog2(NUM_HREGS) : 1;
	localparam int HCNT_W    = $clog2(NUM_HREGS + 1);
	// wide enough for a byte count and for N plus the trailer length
	localparam int CMP_W     = 9;

	// frame layout
	localparam logic [7:0]  FRAME_TAIL     = 8'hEE;
	localparam logic [7:0]  SLAVE_ADDR_RST = 8'h40;
	localparam logic [15:0] CRC_POLY       = 16'h1021;
	localparam int          MIN_FRAME      = 6;
	localparam int          DATA_OFS       = 3;
	localparam int          TAIL_OFS       = 5;
	localparam int          CRC_BYTES      = 3;
	localparam int          REPLY_LEN      = 6;

	// request codes
	localparam logic [1:0] REQ_BYTE = 2'd0;
	localparam logic [1:0] REQ_EOF  = 2'd1;
	localparam logic [1:0] REQ_READ = 2'd2;

	// result kinds
	localparam logic RES_REPLY = 1'b0;
	localparam logic RES_READ  = 1'b1;

endpackage

// ===== sv/fwrs_ram.sv =====
// ----------------------------------------------------------------------------
// fwrs_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fwrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== sv/framed_register_write_slave_unit.sv =====
// Received byte: accepted while idle; the next request can follow at once.
// End of frame: per CRC-covered byte a RAM read, a latch and a bit-serial CRC
// shift; per trailer byte a read and a latch; a check; a read and a latch per
// register write; 6 reply bytes at one per cycle while the output drains; a
// dropped short frame ends in the accept cycle. Register read: registered result.
// Reset clears control, count, overflow, holding registers; address is 0x40.
// ----------------------------------------------------------------------------
// framed_register_write_slave_unit - framed register write slave
// Collects frame bytes, checks length, CRC-16/XMODEM, tail and address on
// end of frame, writes holding registers, emits a six-byte reply and answers register reads.
// ----------------------------------------------------------------------------
module framed_register_write_slave_unit
	import fwrs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] req_type,
	input  logic [7:0] rx_byte,
	input  logic [3:0] reg_index,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       result_kind,
	output logic [7:0] tx_byte,
	output logic       tx_last,
	output logic [7:0] read_value
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_P1_RD  = 4'd1;
	localparam logic [3:0] S_P1_LAT = 4'd2;
	localparam logic [3:0] S_P1_SH  = 4'd3;
	localparam logic [3:0] S_CHECK  = 4'd4;
	localparam logic [3:0] S_P2_RD  = 4'd5;
	localparam logic [3:0] S_P2_LAT = 4'd6;
	localparam logic [3:0] S_TX     = 4'd7;
	localparam logic [3:0] S_RDOUT  = 4'd8;

	logic [3:0]        state_q;
	logic [7:0]        slave_address_q;
	logic [CNT_W-1:0]  count_q;
	logic              overflow_q;
	logic [7:0]        hreg_q [NUM_HREGS];

	logic [CNT_W-1:0]  idx_q;
	logic [2:0]        bit_q;
	logic [7:0]        sh_q;
	logic [15:0]       crc_q;
	logic [15:0]       crc2_q;
	logic [7:0]        hdr_q;
	logic [7:0]        adr_q;
	logic [7:0]        n_q;
	logic [7:0]        got_hi_q;
	logic [7:0]        got_lo_q;
	logic [7:0]        tail_q;
	logic [HCNT_W-1:0] wcnt_q;
	logic [2:0]        txk_q;
	logic [3:0]        rdidx_q;

	logic              out_valid_q;
	logic              result_kind_q;
	logic [7:0]        tx_byte_q;
	logic              tx_last_q;
	logic [7:0]        read_value_q;

	logic              in_acc;
	logic              out_free;
	logic              ram_we;
	logic [7:0]        ram_rdata;
	logic [CNT_W-1:0]  crc_end;
	logic              frame_ok;
	logic [HCNT_W-1:0] wcnt_d;
	logic [HIDX_W-1:0] hidx;
	logic [7:0]        rd_val;
	logic [7:0]        reply_byte;
	logic              fb1;
	logic              fb2;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign ram_we   = in_acc && (req_type == REQ_BYTE) && (count_q < CNT_W'(RX_DEPTH));
	assign crc_end  = count_q - CNT_W'(CRC_BYTES);
	assign hidx     = HIDX_W'(idx_q - CNT_W'(DATA_OFS));
	assign fb1      = crc_q[15] ^ sh_q[7];
	assign fb2      = crc2_q[15] ^ sh_q[7];

	// frame buffer
	fwrs_ram #(
		.WIDTH (8),
		.DEPTH (RX_DEPTH)
	) u_rx_buf (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (count_q[RX_AW-1:0]),
		.wr_data (rx_byte),
		.rd_addr (idx_q[RX_AW-1:0]),
		.rd_data (ram_rdata)
	);

	// frame acceptance and register write count
	always_comb begin
		frame_ok = (CMP_W'(count_q) >= CMP_W'(n_q) + CMP_W'(MIN_FRAME)) &&
		           ({got_hi_q, got_lo_q} == crc_q) &&
		           (tail_q == FRAME_TAIL) &&
		           (adr_q == slave_address_q);
		wcnt_d = (n_q < 8'(NUM_HREGS)) ? HCNT_W'(n_q) : HCNT_W'(NUM_HREGS);
	end

	// select holding register for a read, zero when out of range
	always_comb begin
		rd_val = 8'h00;
		for (int j = 0; j < NUM_HREGS; j++) begin
			if ({28'd0, rdidx_q} == 32'(j)) begin
				rd_val = hreg_q[j];
			end
		end
	end

	// pick reply byte in transmit order
	always_comb begin
		case (txk_q)
			3'd0:    reply_byte = hdr_q;
			3'd1:    reply_byte = adr_q;
			3'd2:    reply_byte = n_q;
			3'd3:    reply_byte = crc2_q[15:8];
			3'd4:    reply_byte = crc2_q[7:0];
			default: reply_byte = tail_q;
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q <= SLAVE_ADDR_RST;
		end else if (cfg_wr_en) begin
			slave_address_q <= cfg_wr_data;
		end
	end

	// control sequencer, byte count and holding registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			overflow_q <= 1'b0;
			idx_q      <= '0;
			bit_q      <= '0;
			txk_q      <= '0;
			for (int j = 0; j < NUM_HREGS; j++) begin
				hreg_q[j] <= 8'h00;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (req_type)
							REQ_BYTE: begin
								if (count_q < CNT_W'(RX_DEPTH)) begin
									count_q <= count_q + CNT_W'(1);
								end else begin
									overflow_q <= 1'b1;
								end
							end
							REQ_EOF: begin
								if (overflow_q || count_q < CNT_W'(MIN_FRAME)) begin
									count_q    <= '0;
									overflow_q <= 1'b0;
								end else begin
									idx_q   <= '0;
									state_q <= S_P1_RD;
								end
							end
							REQ_READ: state_q <= S_RDOUT;
							default: ;
						endcase
					end
				end
				S_P1_RD: state_q <= S_P1_LAT;
				S_P1_LAT: begin
					bit_q <= '0;
					if (idx_q < crc_end) begin
						state_q <= S_P1_SH;
					end else if (idx_q == count_q - CNT_W'(1)) begin
						state_q <= S_CHECK;
					end else begin
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= S_P1_RD;
					end
				end
				S_P1_SH: begin
					bit_q <= bit_q + 3'd1;
					if (bit_q == 3'd7) begin
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= S_P1_RD;
					end
				end
				S_CHECK: begin
					count_q    <= '0;
					overflow_q <= 1'b0;
					txk_q      <= '0;
					if (!frame_ok) begin
						state_q <= S_IDLE;
					end else if (wcnt_d == '0) begin
						state_q <= S_TX;
					end else begin
						idx_q   <= CNT_W'(DATA_OFS);
						state_q <= S_P2_RD;
					end
				end
				S_P2_RD: state_q <= S_P2_LAT;
				S_P2_LAT: begin
					hreg_q[hidx] <= ram_rdata;
					if (HCNT_W'(hidx) + HCNT_W'(1) == wcnt_q) begin
						state_q <= S_TX;
					end else begin
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= S_P2_RD;
					end
				end
				S_TX: begin
					if (out_free) begin
						txk_q <= txk_q + 3'd1;
						if (txk_q == 3'(REPLY_LEN - 1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_RDOUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// capture frame fields and advance the bit-serial CRCs
	always_ff @(posedge clk) begin
		if (in_acc && req_type == REQ_EOF) begin
			crc_q  <= '0;
			crc2_q <= '0;
		end
		if (in_acc && req_type == REQ_READ) begin
			rdidx_q <= reg_index;
		end
		if (state_q == S_P1_LAT) begin
			sh_q <= ram_rdata;
			if (idx_q == CNT_W'(0)) hdr_q <= ram_rdata;
			if (idx_q == CNT_W'(1)) adr_q <= ram_rdata;
			if (idx_q == CNT_W'(2)) n_q <= ram_rdata;
			if (idx_q == crc_end) got_hi_q <= ram_rdata;
			if (idx_q == crc_end + CNT_W'(1)) got_lo_q <= ram_rdata;
			if (CMP_W'(idx_q) == CMP_W'(n_q) + CMP_W'(TAIL_OFS)) tail_q <= ram_rdata;
		end
		if (state_q == S_P1_SH) begin
			sh_q  <= {sh_q[6:0], 1'b0};
			crc_q <= {crc_q[14:0], 1'b0} ^ (fb1 ? CRC_POLY : 16'h0000);
			if (idx_q < CNT_W'(CRC_BYTES)) begin
				crc2_q <= {crc2_q[14:0], 1'b0} ^ (fb2 ? CRC_POLY : 16'h0000);
			end
		end
		if (state_q == S_CHECK) begin
			wcnt_q <= wcnt_d;
		end
	end

	// output register: hold until taken, load reply bytes or read results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free && (state_q == S_TX || state_q == S_RDOUT)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && state_q == S_TX) begin
			result_kind_q <= RES_REPLY;
			tx_byte_q     <= reply_byte;
			tx_last_q     <= (txk_q == 3'(REPLY_LEN - 1));
			read_value_q  <= 8'h00;
		end else if (out_free && state_q == S_RDOUT) begin
			result_kind_q <= RES_READ;
			tx_byte_q     <= 8'h00;
			tx_last_q     <= 1'b0;
			read_value_q  <= rd_val;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = result_kind_q;
	assign tx_byte     = tx_byte_q;
	assign tx_last     = tx_last_q;
	assign read_value  = read_value_q;

	// checks on sequencer and buffer bookkeeping
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(RX_DEPTH))
		else $error("byte count beyond buffer depth");

	a_idle_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |=> state_q == S_IDLE || state_q == S_P1_RD || state_q == S_RDOUT)
		else $error("illegal exit from idle");

	a_last_is_reply: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && tx_last_q |-> result_kind_q == RES_REPLY)
		else $error("last flag on a read result");

	a_walk_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_P1_RD |-> !overflow_q && count_q >= CNT_W'(MIN_FRAME))
		else $error("frame walk started on a dropped frame");

	a_hreg_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_P2_LAT |-> HCNT_W'(hidx) < wcnt_q)
		else $error("holding register write beyond count");

endmodule

// ===== tb/framed_register_write_slave_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_register_write_slave_unit_tb - self-checking bench for the slave
// Feeds serial bytes, end-of-frame and register read requests through the
// valid/ready request channel, predicts every reply byte and read value with
// a local model of the frame buffer and holding registers, and checks each
// output transaction field by field. The slave address is moved through
// several values, the extremes included, while the slave sits idle.
// ----------------------------------------------------------------------------
module framed_register_write_slave_unit_tb;
	import fwrs_pkg::*;

	localparam logic [1:0]  REQ_UNUSED   = 2'd3;
	// quiet time before an address write, longer than the worst end-of-frame walk
	localparam int unsigned QUIET_CYCLES = 600;
	localparam int unsigned IDLE_LIMIT   = 4000;
	localparam int unsigned PHASE_ITEMS  = 80;

	typedef enum logic [1:0] {STEP_REQ, STEP_SETTLE, STEP_ADDR} step_kind_t;
	typedef enum int unsigned {
		FLAW_NONE, FLAW_CRC, FLAW_TAIL, FLAW_ADDR, FLAW_SHORT, FLAW_OVERFLOW
	} flaw_t;

	typedef struct {
		step_kind_t  kind;
		logic [1:0]  req;
		logic [7:0]  data;
		logic [3:0]  idx;
		int unsigned gap;
	} req_step_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] tx;
		logic       last;
		logic [7:0] rval;
	} slave_out_t;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       cfg_wr_en   = 1'b0;
	logic [7:0] cfg_wr_data = 8'h00;
	logic       in_valid    = 1'b0;
	logic       in_ready;
	logic [1:0] req_type    = REQ_BYTE;
	logic [7:0] rx_byte     = 8'h00;
	logic [3:0] reg_index   = 4'h0;
	logic       out_valid;
	logic       out_ready   = 1'b1;
	logic       result_kind;
	logic [7:0] tx_byte;
	logic       tx_last;
	logic [7:0] read_value;

	// model state
	logic [7:0]  rx_img [RX_DEPTH]   = '{default: 8'h00};
	logic [7:0]  hreg_img [NUM_HREGS] = '{default: 8'h00};
	int unsigned rx_len   = 0;
	logic        rx_ovf   = 1'b0;
	logic [7:0]  addr_img = SLAVE_ADDR_RST;

	req_step_t   req_q [$];
	slave_out_t  reply_read_q [$];

	bit          steady       = 1'b0;
	bit          stim_done    = 1'b0;
	int unsigned planned      = 0;
	int unsigned gap_cnt      = 0;
	int unsigned quiet_cnt    = 0;
	int unsigned stall_left   = 0;
	int unsigned idle_cycles  = 0;
	int unsigned mismatches   = 0;
	int unsigned reqs_taken   = 0;
	int unsigned results_seen = 0;
	int unsigned frames_ok    = 0;
	int unsigned frames_drop  = 0;
	int unsigned reads_done   = 0;
	int unsigned addr_writes  = 0;

	framed_register_write_slave_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.rx_byte     (rx_byte),
		.reg_index   (reg_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_kind (result_kind),
		.tx_byte     (tx_byte),
		.tx_last     (tx_last),
		.read_value  (read_value)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// one byte of CRC-16/XMODEM, MSB first, no reflection
	function automatic logic [15:0] crc16_xmodem_byte(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++)
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		return c;
	endfunction

	// advance the slave image by one accepted request
	task automatic slave_step(logic [1:0] req, logic [7:0] b, logic [3:0] idx);
		slave_out_t  r;
		logic [7:0]  reply [REPLY_LEN];
		logic [15:0] crc;
		int unsigned n, i;
		bit          ok;
		n = 0;
		case (req)
		REQ_BYTE: begin
			if (rx_len < RX_DEPTH) begin
				rx_img[rx_len] = b;
				rx_len++;
			end else begin
				rx_ovf = 1'b1;
			end
		end
		REQ_EOF: begin
			ok = !rx_ovf && rx_len >= MIN_FRAME;
			if (ok) begin
				n  = rx_img[2];
				ok = rx_len >= n + MIN_FRAME;
			end
			if (ok) begin
				crc = '0;
				for (i = 0; i + CRC_BYTES < rx_len; i++)
					crc = crc16_xmodem_byte(crc, rx_img[i]);
				ok = crc == {rx_img[rx_len - 3], rx_img[rx_len - 2]} &&
					rx_img[n + TAIL_OFS] == FRAME_TAIL && rx_img[1] == addr_img;
			end
			if (ok) begin
				// data beyond the register file is dropped, N is still echoed
				for (i = 0; i < n && i < NUM_HREGS; i++)
					hreg_img[i] = rx_img[DATA_OFS + i];
				reply[0] = rx_img[0];
				reply[1] = rx_img[1];
				reply[2] = rx_img[2];
				crc = '0;
				for (i = 0; i < 3; i++)
					crc = crc16_xmodem_byte(crc, reply[i]);
				reply[3] = crc[15:8];
				reply[4] = crc[7:0];
				reply[5] = rx_img[n + TAIL_OFS];
				for (i = 0; i < REPLY_LEN; i++) begin
					r.kind = RES_REPLY;
					r.tx   = reply[i];
					r.last = (i == REPLY_LEN - 1);
					r.rval = 8'h00;
					reply_read_q.push_back(r);
				end
				frames_ok++;
			end else begin
				frames_drop++;
			end
			rx_len = 0;
			rx_ovf = 1'b0;
		end
		REQ_READ: begin
			r.kind = RES_READ;
			r.tx   = 8'h00;
			r.last = 1'b0;
			r.rval = (idx < NUM_HREGS) ? hreg_img[idx] : 8'h00;
			reply_read_q.push_back(r);
			reads_done++;
		end
		default: ;
		endcase
	endtask

	task automatic queue_req(logic [1:0] req, logic [7:0] data, logic [3:0] idx);
		req_step_t s;
		s.kind = STEP_REQ;
		s.req  = req;
		s.data = data;
		s.idx  = idx;
		s.gap  = steady ? 0 : $urandom_range(0, 7);
		req_q.push_back(s);
		if (req != REQ_UNUSED)
			planned++;
	endtask

	task automatic queue_marker(step_kind_t kind, logic [7:0] data);
		req_step_t s;
		s.kind = kind;
		s.req  = REQ_BYTE;
		s.data = data;
		s.idx  = '0;
		s.gap  = 0;
		req_q.push_back(s);
	endtask

	// build one frame of N data bytes plus optional padding, then flaw it
	task automatic queue_frame(logic [7:0] addr, int unsigned n, int unsigned pad,
			flaw_t flaw, bit extreme);
		logic [7:0]  fb [$];
		logic [15:0] crc;
		int unsigned len, cut, i, k;
		len = n + MIN_FRAME + pad;
		for (i = 0; i < len; i++)
			fb.push_back(extreme ? {8{i[0]}} : 8'($urandom_range(0, 255)));
		fb[1] = (flaw == FLAW_ADDR) ? addr ^ 8'($urandom_range(1, 255)) : addr;
		fb[2] = 8'(n);
		fb[n + TAIL_OFS] = (flaw == FLAW_TAIL) ?
			FRAME_TAIL ^ 8'($urandom_range(1, 255)) : FRAME_TAIL;
		crc = '0;
		for (i = 0; i + CRC_BYTES < len; i++)
			crc = crc16_xmodem_byte(crc, fb[i]);
		fb[len - 3] = crc[15:8];
		fb[len - 2] = crc[7:0];
		case (flaw)
		FLAW_CRC: begin
			k = len - 3 + $urandom_range(0, 1);
			fb[k] = fb[k] ^ 8'(1 << $urandom_range(0, 7));
		end
		FLAW_SHORT: begin
			cut = $urandom_range(pad + 1, len);
			repeat (cut) void'(fb.pop_back());
		end
		FLAW_OVERFLOW: begin
			while (fb.size() <= RX_DEPTH)
				fb.push_back(8'($urandom_range(0, 255)));
		end
		default: ;
		endcase
		foreach (fb[j])
			queue_req(REQ_BYTE, fb[j], 4'($urandom_range(0, 15)));
		queue_req(REQ_EOF, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
	endtask

	task automatic queue_random_event(logic [7:0] addr);
		int unsigned pick, n, pad;
		steady = ($urandom_range(0, 3) == 0);
		pick   = $urandom_range(0, 99);
		n      = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 26) : $urandom_range(0, 14);
		pad    = (n <= 23 && $urandom_range(0, 4) == 0) ? $urandom_range(3, 26 - n) : 0;
		if (pick < 50) begin
			queue_frame(addr, n, pad, FLAW_NONE, 1'b0);
		end else if (pick < 70) begin
			queue_req(REQ_READ, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
		end else if (pick < 88) begin
			queue_frame(addr, n, pad, flaw_t'($urandom_range(FLAW_CRC, FLAW_OVERFLOW)), 1'b0);
		end else if (pick < 95) begin
			// line noise: a few stray bytes closed by end of frame
			repeat ($urandom_range(0, 8))
				queue_req(REQ_BYTE, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
			queue_req(REQ_EOF, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
		end else begin
			queue_req(REQ_UNUSED, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
		end
	endtask

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected 0x%02h, actual 0x%02h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// request driver: present queued requests, hold address writes for idle
	always @(posedge clk) begin : drive_blk
		req_step_t head;
		logic      vld_nx;
		logic      wr_nx;
		vld_nx = in_valid;
		wr_nx  = 1'b0;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				slave_step(req_type, rx_byte, reg_index);
				reqs_taken++;
				vld_nx = 1'b0;
			end
			if (!vld_nx && req_q.size() > 0) begin
				head = req_q[0];
				case (head.kind)
				STEP_SETTLE: begin
					if (reply_read_q.size() == 0)
						void'(req_q.pop_front());
				end
				STEP_ADDR: begin
					if (reply_read_q.size() != 0) begin
						quiet_cnt = 0;
					end else if (quiet_cnt < QUIET_CYCLES) begin
						quiet_cnt++;
					end else begin
						wr_nx       = 1'b1;
						cfg_wr_data <= head.data;
						addr_img    = head.data;
						addr_writes++;
						quiet_cnt   = 0;
						void'(req_q.pop_front());
					end
				end
				default: begin
					if (gap_cnt < head.gap) begin
						gap_cnt++;
					end else begin
						vld_nx    = 1'b1;
						req_type  <= head.req;
						rx_byte   <= head.data;
						reg_index <= head.idx;
						gap_cnt   = 0;
						void'(req_q.pop_front());
					end
				end
				endcase
			end
			stim_done = !vld_nx && req_q.size() == 0;
		end
		in_valid  <= vld_nx;
		cfg_wr_en <= wr_nx;
	end

	// result monitor: compare each output transaction, stall ready at random
	always @(posedge clk) begin : capture_blk
		slave_out_t  want;
		logic        rdy_nx;
		int unsigned stall;
		rdy_nx = out_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (reply_read_q.size() == 0) begin
					$display("%0t: expected no result, actual kind=%0d tx=0x%02h last=%0d read=0x%02h",
						$time, result_kind, tx_byte, tx_last, read_value);
					mismatches++;
				end else begin
					want = reply_read_q.pop_front();
					check_field("result_kind", 8'(want.kind), 8'(result_kind));
					check_field("tx_byte", want.tx, tx_byte);
					check_field("tx_last", 8'(want.last), 8'(tx_last));
					check_field("read_value", want.rval, read_value);
				end
				results_seen++;
				// every fourth run of 32 results goes without back-pressure
				stall      = ((results_seen / 32) % 4 == 3) ? 0 : $urandom_range(0, 7);
				rdy_nx     = (stall == 0);
				stall_left = stall;
			end else if (!out_ready) begin
				if (stall_left > 1)
					stall_left--;
				else
					rdy_nx = 1'b1;
			end
		end
		out_ready <= rdy_nx;
	end

	// watchdog: give up when no transaction moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d results outstanding",
					$time, idle_cycles, reply_read_q.size());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin : run_blk
		logic [7:0]  phase_addr;
		int unsigned ph, target;

		// directed: reset contents, ignored code, empty and short frames,
		// a good frame with all-zero and all-one data, range edges, bad CRC
		steady = 1'b1;
		queue_req(REQ_READ, 8'hFF, 4'd0);
		queue_req(REQ_UNUSED, 8'hA5, 4'hF);
		queue_req(REQ_EOF, 8'h00, 4'h0);
		queue_frame(SLAVE_ADDR_RST, 2, 0, FLAW_SHORT, 1'b0);
		steady = 1'b0;
		queue_frame(SLAVE_ADDR_RST, 2, 0, FLAW_NONE, 1'b1);
		queue_req(REQ_READ, 8'h00, 4'd1);
		queue_req(REQ_READ, 8'h00, 4'd15);
		queue_req(REQ_READ, 8'h00, 4'(NUM_HREGS - 1));
		queue_frame(SLAVE_ADDR_RST, 0, 0, FLAW_CRC, 1'b0);

		// random phases, each under its own slave address
		for (ph = 0; ph < 5; ph++) begin
			case (ph)
			0:       phase_addr = 8'h00;
			1:       phase_addr = 8'hFF;
			4:       phase_addr = SLAVE_ADDR_RST;
			default: phase_addr = 8'($urandom_range(1, 254));
			endcase
			queue_marker(STEP_ADDR, phase_addr);
			target = planned + PHASE_ITEMS;
			while (planned + PHASE_ITEMS / 2 < target)
				queue_random_event(phase_addr);
			// let the slave drain completely before going on
			queue_marker(STEP_SETTLE, 8'h00);
			while (planned < target)
				queue_random_event(phase_addr);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (!stim_done || reply_read_q.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);

		$display("Sent %0d requests under %0d address settings; %0d results checked.",
			reqs_taken, addr_writes + 1, results_seen);
		$display("Frames answered: %0d, frames dropped: %0d, register reads: %0d.",
			frames_ok, frames_drop, reads_done);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
sv/fwrs_pkg.sv
sv/fwrs_ram.sv
sv/framed_register_write_slave_unit.sv
tb/framed_register_write_slave_unit_tb.sv
